// ----- src/efs_pkg.sv -----
// Shared types and constants for the elevator floor scheduler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package efs_pkg;

  localparam int unsigned FLOOR_W = 5;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned EV_W    = 2;

  // Depth of the command queue between the front and the back part.
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd0;
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;

  localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EV_W-1:0] EV_TARGET   = 2'd1;
  localparam logic [EV_W-1:0] EV_CONTINUE = 2'd2;
  localparam logic [EV_W-1:0] EV_IDLE     = 2'd3;

  localparam logic REQ_PRESS = 1'b0;

  typedef struct packed {
    logic               req_type;
    logic [FLOOR_W-1:0] floor;
    logic [DIR_W-1:0]   travel_dir;
  } in_item_t;

  typedef struct packed {
    logic [EV_W-1:0]    event_res;
    logic [FLOOR_W-1:0] target_floor;
    logic [FLOOR_W-1:0] stop_floor;
    logic               busy_res;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_IGNORE,
    CMD_PRESS,
    CMD_PASS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [FLOOR_W-1:0] floor;
    logic [DIR_W-1:0]   dir;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

`default_nettype wire

// ----- src/elevator_floor_scheduler_core.sv -----
// Elevator floor scheduler, top level. Instantiates the front classifier,
// the command queue and the back scan engine. Depends on efs_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries button presses
//   and floor-passed events. An item is taken at a clock edge with valid high
//   and stall low. The front classifies it and writes it into a four-entry
//   queue, so up to four items are taken while the back part is working.
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives exactly one
//   result item for each input item, in order.
//   An item that needs no scan (ignored floor, pass while free, pass short of the
//   goal) goes from queue head through the EMIT state to the output register. A
//   press or a pass that reaches the goal scans the pending floors one per
//   cycle, first in the travel direction and then the other way, before its
//   result is emitted; the scan sets the throughput.
//   When the receiver stalls, the result holds in the output register, the
//   back part waits with the next result ready, and the queue fills until
//   in_stall_o rises.
//   Reset clears all pending floors, puts the cabin at floor 1, stopped, with
//   goal floor 1, marks the block free and empties queue and output.
`default_nettype none

module elevator_floor_scheduler_core import efs_pkg::*; #(
  parameter int unsigned FLOORS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  logic  push;
  logic  full;
  logic  pop;
  cmd_t  cmd;
  head_t head;

  efs_front #(
    .FLOORS(FLOORS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  efs_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (cmd),
    .full_o(full),
    .pop_i (pop),
    .head_o(head)
  );

  efs_back #(
    .FLOORS(FLOORS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ----- src/efs_front.sv -----
// Front part of the elevator floor scheduler: accepts input items and
// classifies them into commands. Depends on efs_pkg.
`default_nettype none

module efs_front import efs_pkg::*; #(
  parameter int unsigned FLOORS = 16
) (
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  input  wire logic     full_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic floor_ok;

  assign floor_ok = (in_item_i.floor != '0) &&
                    (32'(in_item_i.floor) <= 32'(FLOORS));

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.floor = in_item_i.floor;
    // The unused direction code behaves as stopped.
    cmd_o.dir   = (in_item_i.travel_dir == DIR_DOWN || in_item_i.travel_dir == DIR_UP) ?
                  in_item_i.travel_dir : DIR_STOP;
    if (!floor_ok) begin
      cmd_o.kind = CMD_IGNORE;
    end else if (in_item_i.req_type == REQ_PRESS) begin
      cmd_o.kind = CMD_PRESS;
    end else begin
      cmd_o.kind = CMD_PASS;
    end
  end

endmodule

`default_nettype wire

// ----- src/efs_queue.sv -----
// Short command queue between the front and the back part of the
// elevator floor scheduler. Depends on efs_pkg.
`default_nettype none

module efs_queue import efs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output head_t     head_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond its depth");

endmodule

`default_nettype wire

// ----- src/efs_back.sv -----
// Back part of the elevator floor scheduler: holds the floor state, runs the
// target scan one floor per cycle and drives the output register.
// Depends on efs_pkg.
`default_nettype none

module efs_back import efs_pkg::*; #(
  parameter int unsigned FLOORS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire head_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output out_item_t  out_item_o
);

  localparam int unsigned IW = $clog2(FLOORS);
  localparam logic [IW-1:0] LAST_IDX = IW'(FLOORS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [FLOORS-1:0]  pending_q, pending_d;
  logic [FLOOR_W-1:0] cabin_q, cabin_d;
  logic [DIR_W-1:0]   dir_q, dir_d;
  logic [FLOOR_W-1:0] goal_q, goal_d;
  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;

  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      start_q, start_d;
  logic               up_q, up_d;
  logic               second_q, second_d;
  logic               is_press_q, is_press_d;
  logic [FLOOR_W-1:0] floor_q, floor_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q, out_d;

  logic [IW-1:0]      head_idx;
  logic               hit;
  logic               at_end;
  logic [FLOOR_W-1:0] idx_floor;

  assign head_idx  = IW'(head_i.cmd.floor - FLOOR_W'(1));
  assign hit       = pending_q[idx_q];
  assign at_end    = up_q ? (idx_q == LAST_IDX) : (idx_q == '0);
  assign idx_floor = FLOOR_W'({1'b0, idx_q} + (IW + 1)'(1));

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    cabin_d     = cabin_q;
    dir_d       = dir_q;
    goal_d      = goal_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    start_d     = start_q;
    up_d        = up_q;
    second_d    = second_q;
    is_press_d  = is_press_q;
    floor_d     = floor_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          floor_d = head_i.cmd.floor;
          res_d   = '{event_res: EV_NONE, target_floor: '0, stop_floor: '0,
                      busy_res: busy_q};
          state_d = ST_EMIT;
          case (head_i.cmd.kind)
            CMD_PRESS: begin
              pending_d[head_idx] = 1'b1;
              busy_d     = 1'b1;
              is_press_d = 1'b1;
              idx_d      = IW'(cabin_q - FLOOR_W'(1));
              start_d    = IW'(cabin_q - FLOOR_W'(1));
              up_d       = (dir_q == DIR_UP);
              second_d   = 1'b0;
              state_d    = ST_SCAN;
            end
            CMD_PASS: begin
              if (busy_q) begin
                cabin_d = head_i.cmd.floor;
                dir_d   = head_i.cmd.dir;
                if (head_i.cmd.floor == goal_q) begin
                  // Cabin reached its goal: release that floor and rescan.
                  pending_d[head_idx] = 1'b0;
                  res_d.stop_floor = head_i.cmd.floor;
                  is_press_d = 1'b0;
                  idx_d      = head_idx;
                  start_d    = head_idx;
                  up_d       = (head_i.cmd.dir == DIR_UP);
                  second_d   = 1'b0;
                  state_d    = ST_SCAN;
                end
              end
            end
            default: begin
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          goal_d             = idx_floor;
          res_d.event_res    = is_press_q ? EV_TARGET : EV_CONTINUE;
          res_d.target_floor = idx_floor;
          res_d.busy_res     = 1'b1;
          state_d            = ST_EMIT;
        end else if (at_end) begin
          if (!second_q) begin
            second_d = 1'b1;
            up_d     = !up_q;
            idx_d    = start_q;
          end else if (is_press_q) begin
            // A press always leaves its own floor pending, so this is a guard.
            goal_d             = floor_q;
            res_d.event_res    = EV_TARGET;
            res_d.target_floor = floor_q;
            res_d.busy_res     = 1'b1;
            state_d            = ST_EMIT;
          end else begin
            busy_d             = 1'b0;
            res_d.event_res    = EV_IDLE;
            res_d.target_floor = '0;
            res_d.busy_res     = 1'b0;
            state_d            = ST_EMIT;
          end
        end else begin
          idx_d = up_q ? idx_q + IW'(1) : idx_q - IW'(1);
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= '0;
      cabin_q     <= FLOOR_W'(1);
      dir_q       <= DIR_STOP;
      goal_q      <= FLOOR_W'(1);
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      cabin_q     <= cabin_d;
      dir_q       <= dir_d;
      goal_q      <= goal_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    start_q    <= start_d;
    up_q       <= up_d;
    second_q   <= second_d;
    is_press_q <= is_press_d;
    floor_q    <= floor_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> busy_q)
    else $error("target scan running while the scheduler is free");

  a_goal_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (goal_q != '0))
    else $error("busy without a goal floor");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_res == EV_IDLE) |-> !out_q.busy_res)
    else $error("stopped-idle item reports busy");

  a_target_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_res == EV_TARGET || out_q.event_res == EV_CONTINUE))
      |-> (out_q.busy_res && out_q.target_floor != '0))
    else $error("announced target without a floor or while free");

endmodule

`default_nettype wire
